// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, suspended while reset is high
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// concurrent assertion, checked during reset as well
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ----- hdl/msrt_pkg.sv -----
// types and constants of the machine slot reservation table
package msrt_pkg;

   localparam int OP_W     = 2;
   localparam int MACH_W   = 4;
   localparam int START_W  = 6;
   localparam int END_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_CLEAR     = 7'b0000010,
      S_CHECK     = 7'b0000100,
      S_WRITE     = 7'b0001000,
      S_READ      = 7'b0010000,
      S_READ_WAIT = 7'b0100000,
      S_DONE      = 7'b1000000
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage

// ----- hdl/msrt_table_ram.sv -----
// slot table memory, one write and one registered read per cycle
module msrt_table_ram #(
   parameter int AW     = 9,
   parameter int WORD_W = 31
) (
   input  logic                clock,
   input  msrt_pkg::mem_cmd_type cmd,
   input  logic [AW-1:0]       addr,
   input  logic [WORD_W-1:0]   wr_data,
   output logic [WORD_W-1:0]   rd_data
);
   import msrt_pkg::*;

   logic [WORD_W-1:0] mem [2**AW];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/msrt_ctrl.sv -----
// sequencer: clear sweep, reserve check and write walks, cell read
module msrt_ctrl #(
   parameter int MACHINES   = 8,
   parameter int TIME_SLOTS = 64,
   parameter int ID_BITS    = 9,
   parameter int AW         = 9,
   parameter int WORD_W     = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msrt_pkg::OP_W-1:0]     req_operation,
   input  logic [msrt_pkg::MACH_W-1:0]   req_machine,
   input  logic signed [ID_BITS-1:0]     req_job_id,
   input  logic signed [ID_BITS-1:0]     req_op_id,
   input  logic [msrt_pkg::START_W-1:0]  req_start_time,
   input  logic [msrt_pkg::END_W-1:0]    req_end_time,
   output msrt_pkg::mem_cmd_type         mem_cmd,
   output logic [AW-1:0]                 mem_addr,
   output logic [WORD_W-1:0]             mem_wr_data,
   input  logic [WORD_W-1:0]             mem_rd_data,
   input  logic                          rsp_free,
   output logic                          res_load,
   output logic [msrt_pkg::STATUS_W-1:0] res_status,
   output logic signed [ID_BITS-1:0]     res_job,
   output logic signed [ID_BITS-1:0]     res_op,
   output logic [msrt_pkg::START_W-1:0]  res_start,
   output logic [msrt_pkg::END_W-1:0]    res_end
);
   import msrt_pkg::*;

   localparam int SB    = $clog2(TIME_SLOTS);
   localparam int MB    = AW - SB;
   localparam int CNT_W = (SB > END_W ? SB : END_W) + 1;
   localparam logic [31:0] MACH_MAX = 32'(MACHINES);
   localparam logic [31:0] SLOT_MAX = 32'(TIME_SLOTS);

   state_type             state_ff, state_in;
   logic [AW-1:0]         sweep_ff, sweep_in;
   logic                  need_rsp_ff, need_rsp_in;
   logic                  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   logic [ID_BITS-1:0]    job_ff, job_in;
   logic [ID_BITS-1:0]    op_ff, op_in;
   logic [MB-1:0]         mach_ff, mach_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic [END_W-1:0]      end_ff, end_in;
   logic [CNT_W-1:0]      tcnt_ff, tcnt_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ID_BITS-1:0]    rjob_ff, rjob_in;
   logic [ID_BITS-1:0]    rop_ff, rop_in;
   logic [START_W-1:0]    rstart_ff, rstart_in;
   logic [END_W-1:0]      rend_ff, rend_in;

   logic [31:0]      mach_m1;
   logic             mach_ok;
   logic             occupied;
   logic             tcnt_last;
   logic [CNT_W-1:0] end_ext;
   logic [CNT_W-1:0] start_ext;
   logic [CNT_W-1:0] req_start_ext;

   assign mach_m1       = {{(32-MACH_W){1'b0}}, req_machine} - 32'd1;
   assign mach_ok       = (req_machine != '0) &&
                          ({{(32-MACH_W){1'b0}}, req_machine} <= MACH_MAX);
   assign end_ext       = {{(CNT_W-END_W){1'b0}}, end_ff};
   assign start_ext     = {{(CNT_W-START_W){1'b0}}, start_ff};
   assign req_start_ext = {{(CNT_W-START_W){1'b0}}, req_start_time};
   assign tcnt_last     = (tcnt_ff + CNT_W'(1)) == end_ext;
   // occupied when either stored id has its sign bit clear
   assign occupied      = !mem_rd_data[WORD_W-1] || !mem_rd_data[WORD_W-1-ID_BITS];

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      need_rsp_in  = need_rsp_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      job_in       = job_ff;
      op_in        = op_ff;
      mach_in      = mach_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      tcnt_in      = tcnt_ff;
      status_in    = status_ff;
      rjob_in      = rjob_ff;
      rop_in       = rop_ff;
      rstart_in    = rstart_ff;
      rend_in      = rend_ff;
      mem_cmd      = '0;
      res_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               job_in       = req_job_id;
               op_in        = req_op_id;
               mach_in      = mach_m1[MB-1:0];
               start_in     = req_start_time;
               end_in       = req_end_time;
               tcnt_in      = req_start_ext;
               sweep_in     = '0;
               issue_in     = 1'b0;
               pend_in      = 1'b0;
               pend_last_in = 1'b0;
               status_in    = ST_DONE;
               rjob_in      = '1;
               rop_in       = '1;
               rstart_in    = '0;
               rend_in      = '0;
               case (req_operation)
                  OP_CLEAR: begin
                     need_rsp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  OP_RESERVE: begin
                     if (!mach_ok ||
                         ({{(32-END_W){1'b0}}, req_end_time} > SLOT_MAX)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if ({1'b0, req_start_time} >= req_end_time) begin
                        state_in = S_DONE;
                     end else begin
                        issue_in = 1'b1;
                        state_in = S_CHECK;
                     end
                  end
                  OP_READ: begin
                     if (!mach_ok ||
                         ({{(32-START_W){1'b0}}, req_start_time} >= SLOT_MAX)) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            sweep_in      = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               need_rsp_in = 1'b0;
               state_in    = need_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_CHECK: begin
            // reads issue one per cycle, data is checked in the cycle after
            if (issue_ff) begin
               mem_cmd.rd_en = 1'b1;
               tcnt_in       = tcnt_ff + CNT_W'(1);
               if (tcnt_last) begin
                  issue_in = 1'b0;
               end
            end
            pend_in      = issue_ff;
            pend_last_in = issue_ff && tcnt_last;
            if (pend_ff) begin
               if (occupied) begin
                  status_in = ST_CONFLICT;
                  issue_in  = 1'b0;
                  pend_in   = 1'b0;
                  state_in  = S_DONE;
               end else if (pend_last_ff) begin
                  tcnt_in  = start_ext;
                  pend_in  = 1'b0;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_cmd.wr_en = 1'b1;
            tcnt_in       = tcnt_ff + CNT_W'(1);
            if (tcnt_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            mem_cmd.rd_en = 1'b1;
            state_in      = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            rjob_in   = mem_rd_data[WORD_W-1 -: ID_BITS];
            rop_in    = mem_rd_data[WORD_W-1-ID_BITS -: ID_BITS];
            rstart_in = mem_rd_data[END_W +: START_W];
            rend_in   = mem_rd_data[END_W-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign mem_addr    = (state_ff == S_CLEAR) ? sweep_ff : {mach_ff, tcnt_ff[SB-1:0]};
   assign mem_wr_data = (state_ff == S_CLEAR) ?
                        {job_ff, op_ff, {(START_W+END_W){1'b0}}} :
                        {job_ff, op_ff, start_ff, end_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         need_rsp_ff  <= 1'b0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         job_ff       <= '1;
         op_ff        <= '1;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         need_rsp_ff  <= need_rsp_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         job_ff       <= job_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      mach_ff   <= mach_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      tcnt_ff   <= tcnt_in;
      status_ff <= status_in;
      rjob_ff   <= rjob_in;
      rop_ff    <= rop_in;
      rstart_ff <= rstart_in;
      rend_ff   <= rend_in;
   end

   assign res_status = status_ff;
   assign res_job    = rjob_ff;
   assign res_op     = rop_ff;
   assign res_start  = rstart_ff;
   assign res_end    = rend_ff;

endmodule

// ----- hdl/msrt_rsp_reg.sv -----
// result output register, holds a transaction until it is taken
module msrt_rsp_reg #(
   parameter int ID_BITS = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [msrt_pkg::STATUS_W-1:0] in_status,
   input  logic signed [ID_BITS-1:0]     in_job,
   input  logic signed [ID_BITS-1:0]     in_op,
   input  logic [msrt_pkg::START_W-1:0]  in_start,
   input  logic [msrt_pkg::END_W-1:0]    in_end,
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msrt_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [ID_BITS-1:0]     rsp_cell_job,
   output logic signed [ID_BITS-1:0]     rsp_cell_op,
   output logic [msrt_pkg::START_W-1:0]  rsp_cell_start,
   output logic [msrt_pkg::END_W-1:0]    rsp_cell_end
);
   import msrt_pkg::*;

   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ID_BITS-1:0]  job_ff;
   logic [ID_BITS-1:0]  op_ff;
   logic [START_W-1:0]  start_ff;
   logic [END_W-1:0]    end_ff;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= in_status;
         job_ff    <= in_job;
         op_ff     <= in_op;
         start_ff  <= in_start;
         end_ff    <= in_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_cell_job   = job_ff;
   assign rsp_cell_op    = op_ff;
   assign rsp_cell_start = start_ff;
   assign rsp_cell_end   = end_ff;

endmodule

// ----- hdl/machine_slot_reservation_table.sv -----
// steps: read is one cell read, reserve of n slots is up to n check reads then n writes, clear
// walks every memory row, AW = clog2(MACHINES) + clog2(TIME_SLOTS), 512 rows by default
// one transaction at a time: a request is taken only while the sequencer is idle; the next request
// can be taken at the edge the result can first be taken
// reset: a clearing pass over all 2**AW rows fills the table with empty ids, req_ready stays low
// meanwhile; a waiting result does not stop the next request being taken
module machine_slot_reservation_table #(
   parameter int MACHINES   = 8,
   parameter int TIME_SLOTS = 64,
   parameter int ID_BITS    = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [msrt_pkg::OP_W-1:0]     req_operation,
   input  logic [msrt_pkg::MACH_W-1:0]   req_machine,
   input  logic signed [ID_BITS-1:0]     req_job_id,
   input  logic signed [ID_BITS-1:0]     req_op_id,
   input  logic [msrt_pkg::START_W-1:0]  req_start_time,
   input  logic [msrt_pkg::END_W-1:0]    req_end_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [msrt_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [ID_BITS-1:0]     rsp_cell_job,
   output logic signed [ID_BITS-1:0]     rsp_cell_op,
   output logic [msrt_pkg::START_W-1:0]  rsp_cell_start,
   output logic [msrt_pkg::END_W-1:0]    rsp_cell_end
);
   import msrt_pkg::*;

   // memory row address is {machine index, slot}, rows past TIME_SLOTS go unused
   localparam int SB     = $clog2(TIME_SLOTS);
   localparam int MB     = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int AW     = MB + SB;
   // one word per cell: job id, operation id, start, end
   localparam int WORD_W = 2 * ID_BITS + START_W + END_W;

   mem_cmd_type         mem_cmd;
   logic [AW-1:0]       mem_addr;
   logic [WORD_W-1:0]   mem_wr_data;
   logic [WORD_W-1:0]   mem_rd_data;

   // finished result handed from the sequencer to the output register
   logic                res_load;
   logic                rsp_free;
   logic [STATUS_W-1:0] res_status;
   logic [ID_BITS-1:0]  res_job;
   logic [ID_BITS-1:0]  res_op;
   logic [START_W-1:0]  res_start;
   logic [END_W-1:0]    res_end;

   // cell storage
   msrt_table_ram #(
      .AW     (AW),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // sequencer owns the only memory port; check and write phases never overlap
   msrt_ctrl #(
      .MACHINES   (MACHINES),
      .TIME_SLOTS (TIME_SLOTS),
      .ID_BITS    (ID_BITS),
      .AW         (AW),
      .WORD_W     (WORD_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_machine    (req_machine),
      .req_job_id     (req_job_id),
      .req_op_id      (req_op_id),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .mem_cmd        (mem_cmd),
      .mem_addr       (mem_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_data    (mem_rd_data),
      .rsp_free       (rsp_free),
      .res_load       (res_load),
      .res_status     (res_status),
      .res_job        (res_job),
      .res_op         (res_op),
      .res_start      (res_start),
      .res_end        (res_end)
   );

   // output register decouples the result side from the sequencer
   msrt_rsp_reg #(
      .ID_BITS (ID_BITS)
   ) u_rsp (
      .clock          (clock),
      .reset          (reset),
      .load           (res_load),
      .in_status      (res_status),
      .in_job         (res_job),
      .in_op          (res_op),
      .in_start       (res_start),
      .in_end         (res_end),
      .free           (rsp_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_cell_job   (rsp_cell_job),
      .rsp_cell_op    (rsp_cell_op),
      .rsp_cell_start (rsp_cell_start),
      .rsp_cell_end   (rsp_cell_end)
   );

endmodule

// ----- hdl/msrt_checker.sv -----
// port-level checks of the reservation table, bound to the top level
`include "assert_macros.svh"

module msrt_checker #(
   parameter int ID_BITS = 9
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [msrt_pkg::STATUS_W-1:0] rsp_status,
   input logic [ID_BITS-1:0]            rsp_cell_job,
   input logic [ID_BITS-1:0]            rsp_cell_op,
   input logic [msrt_pkg::START_W-1:0]  rsp_cell_start,
   input logic [msrt_pkg::END_W-1:0]    rsp_cell_end
);
   import msrt_pkg::*;

   // a stalled result keeps its status and both ids
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_cell_job) && $stable(rsp_cell_op))

   // one transaction in flight: ready drops right after a request is taken
   `ASSERT_RST(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready)

   // non-done results carry the empty cell fields
   `ASSERT_RST(a_fixed_fields, clock, reset, rsp_valid && (rsp_status != ST_DONE) |-> (rsp_cell_job == '1) && (rsp_cell_op == '1) && (rsp_cell_start == '0) && (rsp_cell_end == '0))

   // clearing pass keeps requests out right after reset
   `ASSERT_ALWAYS(a_reset_busy, clock, $past(reset) |-> !req_ready)

endmodule

bind machine_slot_reservation_table msrt_checker #(
   .ID_BITS (ID_BITS)
) u_msrt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_cell_job   (rsp_cell_job),
   .rsp_cell_op    (rsp_cell_op),
   .rsp_cell_start (rsp_cell_start),
   .rsp_cell_end   (rsp_cell_end)
);

// ----- verif/msrt_reply_checker.sv -----
// reply checker for the machine slot reservation table: shadow table, reply queue, compare
module msrt_reply_checker #(
   parameter int MACHINES   = 8,
   parameter int TIME_SLOTS = 64,
   parameter int ID_BITS    = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [msrt_pkg::OP_W-1:0]     req_operation,
   input  logic [msrt_pkg::MACH_W-1:0]   req_machine,
   input  logic signed [ID_BITS-1:0]     req_job_id,
   input  logic signed [ID_BITS-1:0]     req_op_id,
   input  logic [msrt_pkg::START_W-1:0]  req_start_time,
   input  logic [msrt_pkg::END_W-1:0]    req_end_time,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [msrt_pkg::STATUS_W-1:0] rsp_status,
   input  logic signed [ID_BITS-1:0]     rsp_cell_job,
   input  logic signed [ID_BITS-1:0]     rsp_cell_op,
   input  logic [msrt_pkg::START_W-1:0]  rsp_cell_start,
   input  logic [msrt_pkg::END_W-1:0]    rsp_cell_end,
   output int                            n_mismatch,
   output int                            outstanding,
   output int                            n_checked,
   output int                            n_conflict,
   output int                            n_range
);
   import msrt_pkg::*;

   localparam int CELLS = MACHINES * TIME_SLOTS;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [ID_BITS-1:0] cell_job;
      logic signed [ID_BITS-1:0] cell_op;
      logic [START_W-1:0]        cell_start;
      logic [END_W-1:0]          cell_end;
   } reply_type;

   logic [ID_BITS-1:0] shadow_job   [CELLS];
   logic [ID_BITS-1:0] shadow_op    [CELLS];
   logic [START_W-1:0] shadow_start [CELLS];
   logic [END_W-1:0]   shadow_end   [CELLS];

   reply_type pending_replies [$];
   reply_type want;
   int fails = 0;
   int checked = 0;
   int conflicts = 0;
   int ranges = 0;
   int queued = 0;

   assign n_mismatch  = fails;
   assign outstanding = queued;
   assign n_checked   = checked;
   assign n_conflict  = conflicts;
   assign n_range     = ranges;

   function automatic void fill_shadow(logic [ID_BITS-1:0] job, logic [ID_BITS-1:0] opid);
      for (int k = 0; k < CELLS; k++) begin
         shadow_job[k]   = job;
         shadow_op[k]    = opid;
         shadow_start[k] = '0;
         shadow_end[k]   = '0;
      end
   endfunction

   // a cell is taken when either id has its sign bit clear
   function automatic bit cell_taken(int idx);
      return !shadow_job[idx][ID_BITS-1] || !shadow_op[idx][ID_BITS-1];
   endfunction

   function automatic reply_type apply_to_table(logic [OP_W-1:0] op, logic [MACH_W-1:0] mach,
                                                logic [ID_BITS-1:0] job,
                                                logic [ID_BITS-1:0] opid,
                                                logic [START_W-1:0] st,
                                                logic [END_W-1:0] en);
      reply_type r;
      int        base;
      bit        clash;
      bit        mach_ok;
      r.status     = ST_DONE;
      r.cell_job   = '1;
      r.cell_op    = '1;
      r.cell_start = '0;
      r.cell_end   = '0;
      mach_ok = (int'(mach) >= 1) && (int'(mach) <= MACHINES);
      base    = (int'(mach) - 1) * TIME_SLOTS;
      case (op)
         OP_CLEAR: begin
            fill_shadow(job, opid);
         end
         OP_RESERVE: begin
            if (!mach_ok || int'(en) > TIME_SLOTS) begin
               r.status = ST_RANGE;
            end else begin
               clash = 1'b0;
               for (int t = int'(st); t < int'(en); t++)
                  if (cell_taken(base + t)) clash = 1'b1;
               if (clash) begin
                  r.status = ST_CONFLICT;
               end else begin
                  for (int t = int'(st); t < int'(en); t++) begin
                     shadow_job[base + t]   = job;
                     shadow_op[base + t]    = opid;
                     shadow_start[base + t] = st;
                     shadow_end[base + t]   = en;
                  end
               end
            end
         end
         OP_READ: begin
            if (!mach_ok || int'(st) >= TIME_SLOTS) begin
               r.status = ST_RANGE;
            end else begin
               r.cell_job   = shadow_job[base + int'(st)];
               r.cell_op    = shadow_op[base + int'(st)];
               r.cell_start = shadow_start[base + int'(st)];
               r.cell_end   = shadow_end[base + int'(st)];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expected_val, actual_val);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill_shadow('1, '1);
         pending_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               $error("reply transaction with no request waiting for it");
               fails++;
            end else begin
               want = pending_replies.pop_front();
               checked++;
               if (rsp_status == ST_CONFLICT) conflicts++;
               if (rsp_status == ST_RANGE) ranges++;
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("cell_job", int'($signed(want.cell_job)), int'($signed(rsp_cell_job)));
               check_field("cell_op", int'($signed(want.cell_op)), int'($signed(rsp_cell_op)));
               check_field("cell_start", int'(want.cell_start), int'(rsp_cell_start));
               check_field("cell_end", int'(want.cell_end), int'(rsp_cell_end));
            end
         end
         if (req_valid && req_ready)
            pending_replies.push_back(apply_to_table(req_operation, req_machine, req_job_id,
                                                     req_op_id, req_start_time,
                                                     req_end_time));
      end
      queued <= pending_replies.size();
   end

endmodule

// ----- verif/tb_machine_slot_reservation_table.sv -----
// testbench top for the machine slot reservation table: stimulus, flow control and verdict
module tb_machine_slot_reservation_table;
   import msrt_pkg::*;

   localparam int MACHINES   = 8;
   localparam int TIME_SLOTS = 64;
   localparam int ID_BITS    = 9;

   // code the block treats as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // random transactions per idling phase, three phases
   localparam int PHASE_ITEMS    = 360;
   // long receiver hold-off, enough to back the block up
   localparam int RX_HOLD_CYCLES = 400;
   // a clear walks all 512 rows, so drain for a bit more than that
   localparam int DRAIN_CYCLES   = 520;
   // worst case is every transaction a clear plus stalls, taken a few times over
   localparam int LIMIT_CYCLES   = 2_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation = OP_READ;
   logic [MACH_W-1:0]         req_machine = '0;
   logic signed [ID_BITS-1:0] req_job_id = '0;
   logic signed [ID_BITS-1:0] req_op_id = '0;
   logic [START_W-1:0]        req_start_time = '0;
   logic [END_W-1:0]          req_end_time = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [ID_BITS-1:0] rsp_cell_job;
   logic signed [ID_BITS-1:0] rsp_cell_op;
   logic [START_W-1:0]        rsp_cell_start;
   logic [END_W-1:0]          rsp_cell_end;

   int n_mismatch;
   int outstanding;
   int n_checked;
   int n_conflict;
   int n_range;

   // idle odds in percent for each side, changed per phase
   int snd_idle_pct = 20;
   int rcv_idle_pct = 58;
   bit stall_request = 1'b0;
   int n_sent [4] = '{default: 0};
   int cycles = 0;

   machine_slot_reservation_table #(
      .MACHINES   (MACHINES),
      .TIME_SLOTS (TIME_SLOTS),
      .ID_BITS    (ID_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_machine    (req_machine),
      .req_job_id     (req_job_id),
      .req_op_id      (req_op_id),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_cell_job   (rsp_cell_job),
      .rsp_cell_op    (rsp_cell_op),
      .rsp_cell_start (rsp_cell_start),
      .rsp_cell_end   (rsp_cell_end)
   );

   // watches both channels, keeps its own copy of the table and counts mismatches
   msrt_reply_checker #(
      .MACHINES   (MACHINES),
      .TIME_SLOTS (TIME_SLOTS),
      .ID_BITS    (ID_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_machine    (req_machine),
      .req_job_id     (req_job_id),
      .req_op_id      (req_op_id),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_cell_job   (rsp_cell_job),
      .rsp_cell_op    (rsp_cell_op),
      .rsp_cell_start (rsp_cell_start),
      .rsp_cell_end   (rsp_cell_end),
      .n_mismatch     (n_mismatch),
      .outstanding    (outstanding),
      .n_checked      (n_checked),
      .n_conflict     (n_conflict),
      .n_range        (n_range)
   );

   // free-running clock, period 12
   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d replies still owed", cycles, outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver side: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // present one transaction, with random idle cycles in front, and wait for acceptance
   task automatic offer(input logic [OP_W-1:0] op, input int mach, input int job,
                        input int opid, input int st, input int en);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_machine    <= mach[MACH_W-1:0];
      req_job_id     <= job[ID_BITS-1:0];
      req_op_id      <= opid[ID_BITS-1:0];
      req_start_time <= st[START_W-1:0];
      req_end_time   <= en[END_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent[op]++;
   endtask

   // mostly real ids, some empty, a few anywhere in the 9-bit range
   function automatic int pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(255);
      if (r < 92) return -1;
      return int'($urandom_range(511)) - 256;
   endfunction

   // mostly a real machine, sometimes zero or past the last one
   function automatic int pick_machine();
      int r;
      r = $urandom_range(99);
      if (r < 90) return $urandom_range(MACHINES, 1);
      if (r < 95) return 0;
      return $urandom_range(15, MACHINES + 1);
   endfunction

   task automatic random_transaction();
      int r;
      int st;
      int en;
      int job;
      int opid;
      r = $urandom_range(99);
      if (r < 4) begin
         // clear: usually back to empty, now and then to an all-taken table
         if ($urandom_range(4) == 0) begin
            job  = $urandom_range(255);
            opid = pick_id();
         end else begin
            job  = -int'($urandom_range(256, 1));
            opid = -int'($urandom_range(256, 1));
         end
         offer(OP_CLEAR, $urandom_range(15), job, opid, $urandom_range(63),
               $urandom_range(127));
      end else if (r < 50) begin
         st = $urandom_range(63);
         r  = $urandom_range(99);
         if (r < 5) en = $urandom_range(127, TIME_SLOTS + 1);
         else if (r < 10) en = $urandom_range(st);
         else if (r < 15) en = st + $urandom_range(TIME_SLOTS - st, 1);
         else en = st + $urandom_range(8, 1);
         if (en > 127) en = 127;
         if (r >= 15 && en > TIME_SLOTS) en = TIME_SLOTS;
         offer(OP_RESERVE, pick_machine(), pick_id(), pick_id(), st, en);
      end else if (r < 97) begin
         offer(OP_READ, pick_machine(), pick_id(), pick_id(), $urandom_range(63),
               $urandom_range(127));
      end else begin
         offer(OP_UNUSED, $urandom_range(15), pick_id(), pick_id(), $urandom_range(63),
               $urandom_range(127));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, full-width reservation, overlap, range limits
      offer(OP_READ, 1, 0, 0, 0, 0);
      offer(OP_RESERVE, 1, 255, 255, 0, TIME_SLOTS);
      offer(OP_READ, 1, 0, 0, 63, 0);
      offer(OP_RESERVE, 1, 3, 4, 10, 12);
      offer(OP_RESERVE, 0, 5, 5, 0, 4);
      offer(OP_RESERVE, 15, 5, 5, 0, 4);
      offer(OP_RESERVE, 2, 5, 5, 0, TIME_SLOTS + 1);
      offer(OP_RESERVE, 2, 5, 5, 3, 127);
      // empty intervals are accepted and change nothing
      offer(OP_RESERVE, 2, 6, 6, 5, 5);
      offer(OP_RESERVE, 2, 6, 6, 63, 0);
      // an op id of zero alone marks the cell taken
      offer(OP_RESERVE, MACHINES, -1, 0, 63, 64);
      offer(OP_RESERVE, MACHINES, 7, -1, 62, 64);
      // negative ids leave a cell free, even though times get written
      offer(OP_RESERVE, 3, -1, -1, 0, 1);
      offer(OP_RESERVE, 3, -256, -2, 0, 2);
      offer(OP_READ, 3, 0, 0, 0, 0);
      offer(OP_READ, 0, 0, 0, 0, 0);
      offer(OP_READ, 9, 0, 0, 5, 0);
      offer(OP_UNUSED, 1, 255, 255, 63, 127);
      // clear to taken ids, then back to empty
      offer(OP_CLEAR, 0, 100, -1, 17, 33);
      offer(OP_RESERVE, 4, 1, 1, 0, 1);
      offer(OP_READ, MACHINES, 0, 0, 63, 0);
      offer(OP_CLEAR, 15, -1, 200, 63, 127);
      offer(OP_RESERVE, 5, 1, 1, 20, 21);
      offer(OP_CLEAR, 1, -1, -1, 0, 0);
      offer(OP_READ, 1, 0, 0, 0, 0);

      // phase one: sender idles lightly, receiver heavily
      repeat (PHASE_ITEMS) random_transaction();

      // phase two: the other way round
      snd_idle_pct = 58;
      rcv_idle_pct = 20;
      repeat (PHASE_ITEMS) random_transaction();

      // phase three: no idling; opens with a long receiver hold-off under a read burst
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      stall_request = 1'b1;
      repeat (30) offer(OP_READ, pick_machine(), 0, 0, $urandom_range(63), 0);
      repeat (PHASE_ITEMS) random_transaction();
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d clears, %0d reserves, %0d reads and %0d no-op transactions",
               n_sent[OP_CLEAR], n_sent[OP_RESERVE], n_sent[OP_READ], n_sent[OP_UNUSED]);
      $display("compared %0d replies, %0d of them conflicts and %0d out of range",
               n_checked, n_conflict, n_range);
      if (n_mismatch == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
